// File: hdl/mwie_pkg.sv
`default_nettype none

package mwie_pkg;

  localparam int KEY_W = 32;
  localparam int IDX_W = 11;
  localparam int CNT_W = 12;

  localparam logic [CNT_W-1:0] RADIX_RESET = CNT_W'(1626);
  localparam logic [CNT_W-1:0] RADIX_MAX   = CNT_W'(2048);
  localparam logic [CNT_W-1:0] RADIX_MIN   = CNT_W'(1);

  // Restoring division: one quotient bit per step, a few steps per register stage.
  localparam int STEPS_PER_STAGE = 4;
  localparam int STAGES_PER_DIV  = KEY_W / STEPS_PER_STAGE;
  localparam int NUM_DIVS        = 3;
  localparam int NUM_STAGES      = STAGES_PER_DIV * NUM_DIVS;

  // Work carried down the pipeline. quo starts as the dividend and is shifted
  // left one bit per step while quotient bits enter at the bottom.
  typedef struct packed {
    logic [IDX_W-1:0] rem;
    logic [KEY_W-1:0] quo;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] rem2;
  } work_t;

  // Sum of two residues modulo the radix; both operands are below the radix.
  function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b,
                                               input logic [CNT_W-1:0] radix);
    logic [CNT_W-1:0] sum;
    sum = CNT_W'(a) + CNT_W'(b);
    if (sum >= radix) begin
      sum = sum - radix;
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/mwie_div_stage.sv
`default_nettype none

module mwie_div_stage
  import mwie_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic [CNT_W-1:0] radix,
  input  wire logic             in_vld,
  input  wire work_t            in_work,
  output logic                  vld_r,
  output work_t                 work_r
);

  work_t work_nxt;

  // A group of restoring division steps on a narrow partial remainder.
  always_comb begin
    logic [CNT_W-1:0] part;
    logic [KEY_W-1:0] q;
    logic [IDX_W-1:0] r;
    r = in_work.rem;
    q = in_work.quo;
    part = '0;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      part = {r, q[KEY_W-1]};
      if (part >= radix) begin
        part = part - radix;
        q = {q[KEY_W-2:0], 1'b1};
      end else begin
        q = {q[KEY_W-2:0], 1'b0};
      end
      r = part[IDX_W-1:0];
    end
    work_nxt       = in_work;
    work_nxt.rem   = r;
    work_nxt.quo   = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      work_r <= work_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mnemonic_word_index_encode.sv
`default_nettype none

// Turns one 32-bit key group into three word-list indices in base n, where n
// is the word count register (reset 1626; a written 0 acts as 1 and anything
// above 2048 acts as 2048). The first index is the key group modulo n, the
// second is the quotient plus the first index modulo n, and the third is the
// second quotient plus the second index modulo n. The block takes one beat
// per clock cycle while in_stall is low and gives one result beat for each
// input beat, in order. The path is three restoring dividers by n, each 8
// register stages of 4 quotient bits, then one output register where the two
// modular sums are formed. A stall on a valid output beat freezes the whole
// pipeline, bubbles included, and in_stall follows it in the same cycle.
// Write word_count only while no beat is in flight.
module mnemonic_word_index_encode
  import mwie_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [KEY_W-1:0] in_key_group,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [IDX_W-1:0]      out_first_index,
  output logic [IDX_W-1:0]      out_second_index,
  output logic [IDX_W-1:0]      out_third_index
);

  // The register holds the effective radix, clamped when it is written.
  logic [CNT_W-1:0] radix_r;
  logic [CNT_W-1:0] radix_nxt;

  always_comb begin
    if (cfg_wr_data == '0) begin
      radix_nxt = RADIX_MIN;
    end else if (cfg_wr_data > RADIX_MAX) begin
      radix_nxt = RADIX_MAX;
    end else begin
      radix_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= radix_nxt;
    end
  end

  // The pipeline moves whenever the output register is free or being drained.
  logic adv;
  logic out_valid_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;

  logic  stg_vld  [NUM_STAGES];
  work_t stg_work [NUM_STAGES];

  // At each divider boundary the quotient becomes the next dividend and the
  // remainder just produced is set aside: the key group's remainder is the
  // first index, the first quotient's remainder feeds the second index.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    logic  src_vld;
    work_t src_work;

    if (s == 0) begin : g_head
      assign src_vld  = in_valid;
      assign src_work = '{rem: '0, quo: in_key_group, first: '0, rem2: '0};
    end else if (s == STAGES_PER_DIV) begin : g_second
      assign src_vld  = stg_vld[s-1];
      assign src_work = '{rem: '0, quo: stg_work[s-1].quo,
                          first: stg_work[s-1].rem, rem2: '0};
    end else if (s == 2 * STAGES_PER_DIV) begin : g_third
      assign src_vld  = stg_vld[s-1];
      assign src_work = '{rem: '0, quo: stg_work[s-1].quo,
                          first: stg_work[s-1].first, rem2: stg_work[s-1].rem};
    end else begin : g_mid
      assign src_vld  = stg_vld[s-1];
      assign src_work = stg_work[s-1];
    end

    mwie_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .radix   (radix_r),
      .in_vld  (src_vld),
      .in_work (src_work),
      .vld_r   (stg_vld[s]),
      .work_r  (stg_work[s])
    );
  end

  // Output register. The second index is the first index plus the first
  // quotient modulo n, and the third adds the second quotient's residue.
  logic [IDX_W-1:0] first_r;
  logic [IDX_W-1:0] second_r;
  logic [IDX_W-1:0] third_r;
  logic [IDX_W-1:0] second_nxt;
  logic [IDX_W-1:0] third_nxt;

  assign second_nxt = mod_add(stg_work[NUM_STAGES-1].rem2,
                              stg_work[NUM_STAGES-1].first, radix_r);
  assign third_nxt  = mod_add(stg_work[NUM_STAGES-1].rem, second_nxt, radix_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= stg_vld[NUM_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first_r  <= stg_work[NUM_STAGES-1].first;
      second_r <= second_nxt;
      third_r  <= third_nxt;
    end
  end

  assign out_first_index  = first_r;
  assign out_second_index = second_r;
  assign out_third_index  = third_r;

  // The clamp keeps the radix within the range every index field can carry.
  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    (radix_r != '0) && (radix_r <= RADIX_MAX))
    else $error("radix register outside 1..2048");

  // Every delivered index is a residue of the current radix.
  a_out_residue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((CNT_W'(first_r) < radix_r) && (CNT_W'(second_r) < radix_r)
                     && (CNT_W'(third_r) < radix_r)))
    else $error("result index not below radix");

  // The last divider leaves a remainder below the radix.
  a_last_rem: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld[NUM_STAGES-1] |-> (CNT_W'(stg_work[NUM_STAGES-1].rem) < radix_r))
    else $error("divider remainder not below radix");

  // A frozen pipeline keeps the output beat in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(first_r)
                                    && $stable(second_r) && $stable(third_r)))
    else $error("output beat changed while stalled");

endmodule

`default_nettype wire

// File: tb/sv/mwie_checker.sv
`timescale 1ns / 100ps

module mwie_checker
  import mwie_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  input  wire logic             in_stall,
  input  wire logic [KEY_W-1:0] in_key_group,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  input  wire logic [IDX_W-1:0] out_first_index,
  input  wire logic [IDX_W-1:0] out_second_index,
  input  wire logic [IDX_W-1:0] out_third_index,
  output int                    mismatch_count,
  output int                    beats_pending
);

  typedef struct packed {
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic [IDX_W-1:0] third;
  } index_triple_t;

  logic [CNT_W-1:0] word_count_q;
  index_triple_t    index_queue[$];
  int               result_beats;

  // Three base-n digits of the key group, each offset by the digit below it.
  function automatic index_triple_t encode_indices(input logic [KEY_W-1:0] key,
                                                   input logic [CNT_W-1:0] count);
    longint unsigned x;
    longint unsigned n;
    longint unsigned q1;
    longint unsigned q2;
    index_triple_t   r;
    x = 64'(key);
    if (count == '0) begin
      n = 1;
    end else if (count > RADIX_MAX) begin
      n = 64'(RADIX_MAX);
    end else begin
      n = 64'(count);
    end
    q1       = x / n;
    q2       = q1 / n;
    r.first  = IDX_W'(x % n);
    r.second = IDX_W'((q1 + r.first) % n);
    r.third  = IDX_W'((q2 + r.second) % n);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ERROR: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    index_triple_t want;
    if (!rst_n) begin
      word_count_q = RADIX_RESET;
      index_queue.delete();
      result_beats = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (index_queue.size() == 0) begin
          report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                    result_beats));
        end else begin
          want = index_queue.pop_front();
          if (out_first_index != want.first) begin
            report_mismatch($sformatf("beat %0d first_index got %0d want %0d",
                                      result_beats, out_first_index, want.first));
          end
          if (out_second_index != want.second) begin
            report_mismatch($sformatf("beat %0d second_index got %0d want %0d",
                                      result_beats, out_second_index, want.second));
          end
          if (out_third_index != want.third) begin
            report_mismatch($sformatf("beat %0d third_index got %0d want %0d",
                                      result_beats, out_third_index, want.third));
          end
        end
        result_beats++;
      end
      if (in_valid && !in_stall) begin
        index_queue.push_back(encode_indices(in_key_group, word_count_q));
      end
      if (cfg_wr_en) begin
        word_count_q = cfg_wr_data;
      end
    end
    beats_pending <= index_queue.size();
  end

endmodule

// File: tb/sv/tb_mnemonic_word_index_encode.sv
`timescale 1ns / 100ps

module tb_mnemonic_word_index_encode;
  import mwie_pkg::*;

  // The drain margin below covers the pipeline depth with room to spare.
  localparam int DRAIN_CYCLES     = 40;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int NUM_PHASES       = 12;
  localparam int KEYS_PER_PHASE   = 155;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  logic [KEY_W-1:0] in_key_group;
  logic             out_valid;
  logic             out_stall;
  logic [IDX_W-1:0] out_first_index;
  logic [IDX_W-1:0] out_second_index;
  logic [IDX_W-1:0] out_third_index;

  int mismatch_count;
  int beats_pending;

  // Knobs shared between the key source and the result sink.
  bit tx_idle_on;
  bit rx_idle_on;
  int hold_requests;

  // The radix as the block will use it, only for shaping random keys.
  int unsigned radix_now;

  mnemonic_word_index_encode u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_group     (in_key_group),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first_index  (out_first_index),
    .out_second_index (out_second_index),
    .out_third_index  (out_third_index)
  );

  mwie_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_group     (in_key_group),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first_index  (out_first_index),
    .out_second_index (out_second_index),
    .out_third_index  (out_third_index),
    .mismatch_count   (mismatch_count),
    .beats_pending    (beats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog. Ten milliseconds is far beyond the slowest legal run, so it
  // only trips on a hung handshake.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result sink. Before each result beat it keeps out_stall high for a drawn
  // number of cycles, then drops it and waits for out_valid. A pending long
  // hold request replaces the random draw once, which backs the pipeline up
  // all the way to in_stall while the source keeps offering keys.
  initial begin : result_sink
    int stall_cycles;
    int holds_served;
    out_stall    = 1'b0;
    holds_served = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_requests > holds_served) begin
        holds_served++;
        stall_cycles = LONG_HOLD_CYCLES;
      end else begin
        stall_cycles = rx_idle_on ? $urandom_range(0, 11) : 0;
      end
      repeat (stall_cycles) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one key beat after a drawn gap and returns once it has been taken.
  // When the gap is zero in_valid simply stays high into the next beat.
  task automatic send_key(input logic [KEY_W-1:0] key);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_key_group <= key;
    do @(posedge clk); while (in_stall);
  endtask

  // Lets every beat in flight come out before anything touches the register.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (beats_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_word_count(input logic [CNT_W-1:0] value);
    drain_pipeline();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (value == '0) begin
      radix_now = 1;
    end else if (value > RADIX_MAX) begin
      radix_now = 32'(RADIX_MAX);
    end else begin
      radix_now = 32'(value);
    end
  endtask

  // Random keys biased toward the interesting corners of the radix: small
  // values, values near multiples of n and of n squared, and values just
  // below the top of the 32-bit range. Arithmetic wraps at 32 bits on purpose.
  function automatic logic [KEY_W-1:0] shaped_key(input int unsigned n);
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 5))
      0, 1:    k = $urandom;
      2:       k = $urandom_range(0, 3 * n);
      3:       k = n * n * $urandom_range(0, 1500) + $urandom_range(0, 2) - 1;
      4:       k = ~KEY_W'($urandom_range(0, 3 * n));
      default: k = n * $urandom + $urandom_range(0, n - 1);
    endcase
    return k;
  endfunction

  initial begin : key_source
    logic [CNT_W-1:0] radix_plan [NUM_PHASES];
    logic [KEY_W-1:0] corner_keys [17];
    int               mode;

    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_key_group  = '0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    hold_requests = 0;
    radix_now     = 32'(RADIX_RESET);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, first at the reset radix of 1626: zero, one, the digit
    // boundaries n-1, n, n+1 and n*n-1, n*n, n*n+1, then the top of the key
    // range and a few bit patterns.
    corner_keys = '{32'd0, 32'd1, 32'd1625, 32'd1626, 32'd1627,
                    32'd2643875, 32'd2643876, 32'd2643877,
                    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000,
                    32'd4294967295 - 32'd1626};
    foreach (corner_keys[i]) begin
      send_key(corner_keys[i]);
    end

    // A written zero must act as a radix of one, so every index is zero.
    write_word_count('0);
    send_key(32'd0);
    send_key(32'hFFFF_FFFF);
    send_key(32'd12345);

    // An all-ones write saturates at 2048, the largest radix the fields hold.
    write_word_count('1);
    send_key(32'd2047);
    send_key(32'd2048);
    send_key(32'd4194303);
    send_key(32'hFFFF_FFFF);

    // Random part. Each phase picks a radix, including the extremes and the
    // values just past them, and an idling mode: both sides idle, only the
    // source idles, only the sink stalls, or neither does.
    radix_plan = '{CNT_W'(1626), CNT_W'(2048), CNT_W'(1), CNT_W'(2), CNT_W'(3),
                   CNT_W'(4095), CNT_W'(0), CNT_W'(2047), CNT_W'(1000),
                   CNT_W'(2049), '0, '0};
    radix_plan[10] = CNT_W'($urandom);
    radix_plan[11] = CNT_W'($urandom_range(1, 2048));

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_word_count(radix_plan[phase]);
      mode       = phase % 4;
      tx_idle_on = (mode == 1) || (mode == 2);
      rx_idle_on = (mode == 1) || (mode == 3);
      for (int i = 0; i < KEYS_PER_PHASE; i++) begin
        // In phase three the source streams back to back, and partway in the
        // sink holds off long enough to fill the pipeline and stall the input.
        if (phase == 3 && i == 20) begin
          hold_requests++;
        end
        send_key(shaped_key(radix_now));
      end
    end

    drain_pipeline();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/mwie_pkg.sv
hdl/mwie_div_stage.sv
hdl/mnemonic_word_index_encode.sv
tb/sv/mwie_checker.sv
tb/sv/tb_mnemonic_word_index_encode.sv
